[rtl/core/sdds_pkg.sv]
// Shared types and constants for the signed doubling-subtract divider.
`default_nettype none

package sdds_pkg;

    // Operand and quotient width in bits.
    localparam int unsigned DATA_WIDTH = 32;

    typedef logic [DATA_WIDTH-1:0] data_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } div_status_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] numerator;
        logic signed [DATA_WIDTH-1:0] denominator;
    } div_req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] quotient;
        div_status_t                  status;
    } div_res_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUB,
        S_DBL,
        S_DONE
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic sub;
        logic fallback;
        logic dbl;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic div_zero;
        logic fits;
        logic mult_one;
    } dp_flags_t;

endpackage

`default_nettype wire

[rtl/core/sdds_ctrl.sv]
// Controller state machine that sequences the doubling-subtract loop.
`default_nettype none

module sdds_ctrl
    import sdds_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire dp_flags_t flags,
    output dp_cmd_t        cmd,
    output logic           busy
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                if (flags.div_zero)
                begin
                    state_next = S_DONE;
                end
                else if (flags.fits || !flags.mult_one)
                begin
                    state_next = S_DBL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DBL:
            begin
                state_next = S_SUB;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_SUB:
            begin
                if (!flags.div_zero)
                begin
                    if (flags.fits)
                    begin
                        cmd.sub = 1'b1;
                    end
                    else if (!flags.mult_one)
                    begin
                        cmd.fallback = 1'b1;
                    end
                end
            end
            S_DBL:
            begin
                cmd.dbl = 1'b1;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/sdds_datapath.sv]
// Datapath: operand magnitudes, trial divisor, multiple, quotient and result register.
`default_nettype none

module sdds_datapath
    import sdds_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire dp_cmd_t  cmd,
    input  wire div_req_t request,
    output dp_flags_t     flags,
    output div_res_t      result,
    output logic          done
);

    localparam data_t ONE = data_t'(1);

    data_t    num_reg,   num_next;
    data_t    den_reg,   den_next;
    data_t    trial_reg, trial_next;
    data_t    mult_reg,  mult_next;
    data_t    quot_reg,  quot_next;
    logic     neg_reg,   neg_next;
    logic     dz_reg,    dz_next;
    div_res_t res_reg,   res_next;
    logic     done_reg,  done_next;

    data_t a_raw;
    data_t b_raw;
    data_t a_mag;
    data_t b_mag;
    data_t diff;
    data_t quot_neg;
    logic  can_double;

    assign a_raw = data_t'(request.numerator);
    assign b_raw = data_t'(request.denominator);
    assign a_mag = a_raw[DATA_WIDTH-1] ? data_t'(data_t'(0) - a_raw) : a_raw;
    assign b_mag = b_raw[DATA_WIDTH-1] ? data_t'(data_t'(0) - b_raw) : b_raw;

    assign diff       = num_reg - trial_reg;
    assign can_double = {trial_reg, 1'b0} <= {1'b0, num_reg};
    assign quot_neg   = data_t'(0) - quot_reg;

    assign flags.div_zero = dz_reg;
    assign flags.fits     = trial_reg <= num_reg;
    assign flags.mult_one = mult_reg == ONE;

    always_comb
    begin
        num_next   = num_reg;
        den_next   = den_reg;
        trial_next = trial_reg;
        mult_next  = mult_reg;
        quot_next  = quot_reg;
        neg_next   = neg_reg;
        dz_next    = dz_reg;
        res_next   = res_reg;
        done_next  = 1'b0;

        if (cmd.load)
        begin
            num_next   = a_mag;
            den_next   = b_mag;
            trial_next = b_mag;
            mult_next  = ONE;
            quot_next  = '0;
            neg_next   = a_raw[DATA_WIDTH-1] ^ b_raw[DATA_WIDTH-1];
            dz_next    = b_mag == '0;
        end
        if (cmd.sub)
        begin
            num_next  = diff;
            quot_next = quot_reg + mult_reg;
        end
        if (cmd.fallback)
        begin
            trial_next = den_reg;
            mult_next  = ONE;
        end
        if (cmd.dbl && can_double)
        begin
            trial_next = {trial_reg[DATA_WIDTH-2:0], 1'b0};
            mult_next  = {mult_reg[DATA_WIDTH-2:0], 1'b0};
        end
        if (cmd.finish)
        begin
            done_next = 1'b1;
            if (dz_reg)
            begin
                res_next.quotient = '0;
                res_next.status   = ST_DIV_ZERO;
            end
            else if (!neg_reg && quot_reg[DATA_WIDTH-1])
            begin
                res_next.quotient = '0;
                res_next.status   = ST_OVERFLOW;
            end
            else
            begin
                res_next.quotient = neg_reg ? quot_neg : quot_reg;
                res_next.status   = ST_OK;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        den_reg   <= den_next;
        trial_reg <= trial_next;
        mult_reg  <= mult_next;
        quot_reg  <= quot_next;
        neg_reg   <= neg_next;
        dz_reg    <= dz_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

[rtl/core/signed_divider_doubling_subtract.sv]
// Top level of the signed divider built on doubling subtraction.
//
// Usage: drive both operands on request and raise start. A beat is taken at
// the rising edge where start is high and busy is low. Busy then stays high
// until the quotient is ready. The result beat (quotient and status) is on
// result for exactly one cycle, marked by done; the receiver cannot stall it.
//
// The quotient is truncated toward zero. A zero divisor gives status
// divide-by-zero and the most negative value divided by minus one gives
// status overflow; in both cases the quotient reads zero.
//
// Sequencing: after the accepting edge, each step of the loop runs the
// subtract state and then the doubling state, and the last step goes from
// subtract to done. The step count depends on the operands: it grows
// with the number of doubling runs and is at most about W * (W + 1) / 2 for
// a W-bit operand. A divide by zero goes straight from subtract to done. One
// item is in flight at a time; busy drops in the cycle that done is shown, so
// the next start can be taken there. Reset clears the controller to idle and drops done.
`default_nettype none

module signed_divider_doubling_subtract
    import sdds_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire div_req_t request,
    output div_res_t      result,
    output logic          done
);

    dp_cmd_t   cmd;
    dp_flags_t flags;

    // The controller only sequences; all arithmetic sits in the datapath.
    sdds_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .cmd   (cmd),
        .busy  (busy)
    );

    sdds_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .flags   (flags),
        .result  (result),
        .done    (done)
    );

    // A result beat only appears once the controller is back in idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done raised while busy");

    // An accepted beat keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted beat did not make the block busy");

    // A subtract is issued only when the trial divisor fits the remainder.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.sub |-> flags.fits)
        else $error("subtract issued with a trial that does not fit");

    // Error results carry a zero quotient.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |-> (result.quotient == '0))
        else $error("nonzero quotient on an error result");

endmodule

`default_nettype wire
